/* hdl/dbwp_pkg.sv */
package dbwp_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned GATHER_W   = 24;
  localparam int unsigned COUNT_W    = 48;
  localparam int unsigned FMT_W      = 2;
  localparam int unsigned SLOT_W     = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 48;

  // output formats
  localparam logic [FMT_W-1:0] FMT_U8  = 2'd0;
  localparam logic [FMT_W-1:0] FMT_U16 = 2'd1;
  localparam logic [FMT_W-1:0] FMT_U32 = 2'd2;
  localparam logic [FMT_W-1:0] FMT_DOP = 2'd3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_FORMAT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MONO        = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BIT_REV     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TRACK_BYTES = 2'd3;

  localparam logic [BYTE_W-1:0] SILENCE_BYTE = 8'h69;

  typedef struct packed {
    logic              load;      // store byte into gather
    logic              emit;      // frame complete, result this beat
    logic              clear;     // drop gathered bytes
    logic [SLOT_W-1:0] slot;      // byte position of the incoming byte
    logic [SLOT_W-1:0] len_m1;    // frame length minus one
    logic [FMT_W-1:0]  fmt;
    logic              bit_rev;
    logic              mono;
    logic              last;
  } lane_ctl_t;

endpackage

/* hdl/dbwp_lane.sv */
module dbwp_lane (
  input  logic                              clk,
  input  logic                              rst,
  input  dbwp_pkg::lane_ctl_t               ctl,
  input  logic [dbwp_pkg::BYTE_W-1:0]       byte_in,
  output logic [dbwp_pkg::WORD_W-1:0]       word
);

  logic [dbwp_pkg::GATHER_W-1:0] gather;
  logic [dbwp_pkg::GATHER_W-1:0] gather_next;
  logic [dbwp_pkg::BYTE_W-1:0]   b;
  logic [dbwp_pkg::BYTE_W-1:0]   gb [4];
  logic [dbwp_pkg::BYTE_W-1:0]   pb [4];

  // LSB-first sources: mirror each byte
  always_comb begin
    for (int i = 0; i < dbwp_pkg::BYTE_W; i++) begin
      b[i] = ctl.bit_rev ? byte_in[dbwp_pkg::BYTE_W-1-i] : byte_in[i];
    end
  end

  always_comb begin
    gather_next = gather;
    if (ctl.clear) begin
      gather_next = '0;
    end else if (ctl.load) begin
      case (ctl.slot)
        2'd0:    gather_next[23:16] = gather[23:16] | b;
        2'd1:    gather_next[15:8]  = gather[15:8]  | b;
        default: gather_next[7:0]   = gather[7:0]   | b;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gather <= '0;
    end else begin
      gather <= gather_next;
    end
  end

  assign gb[0] = gather[23:16];
  assign gb[1] = gather[15:8];
  assign gb[2] = gather[7:0];
  assign gb[3] = '0;

  // byte k of the full frame: earlier bytes, newest byte, silence padding
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      pb[k] = gb[k]
            | ((2'(k) == ctl.slot) ? b : '0)
            | ((2'(k) > ctl.slot && 2'(k) <= ctl.len_m1) ? dbwp_pkg::SILENCE_BYTE : '0);
    end
  end

  always_comb begin
    case (ctl.fmt)
      dbwp_pkg::FMT_U8:  word = {pb[0], 24'h0};
      dbwp_pkg::FMT_U16: word = {pb[0], pb[1], 16'h0};
      dbwp_pkg::FMT_U32: word = {pb[0], pb[1], pb[2], pb[3]};
      default:           word = {8'h0, pb[0], pb[1], 8'h0};
    endcase
  end

endmodule

/* hdl/dbwp_ctrl.sv */
module dbwp_ctrl (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [dbwp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dbwp_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                in_fire,
  output dbwp_pkg::lane_ctl_t                 ctl
);

  logic [dbwp_pkg::FMT_W-1:0]   out_format;
  logic                         mono;
  logic                         bit_rev;
  logic [dbwp_pkg::COUNT_W-1:0] remaining;
  logic                         finished;
  logic [dbwp_pkg::SLOT_W-1:0]  byte_slot;

  logic [dbwp_pkg::SLOT_W-1:0]  len_m1;
  logic [dbwp_pkg::SLOT_W-1:0]  slot_eff;
  logic                         active;
  logic                         last;
  logic                         emit;
  logic                         load;
  logic                         cfg_clear;

  always_comb begin
    case (out_format)
      dbwp_pkg::FMT_U8:  len_m1 = 2'd0;
      dbwp_pkg::FMT_U32: len_m1 = 2'd3;
      default:           len_m1 = 2'd1;
    endcase
  end

  assign slot_eff  = (byte_slot > len_m1) ? len_m1 : byte_slot;
  assign active    = in_fire && !finished && (remaining != '0);
  assign last      = (remaining == dbwp_pkg::COUNT_W'(1));
  assign emit      = active && ((slot_eff == len_m1) || last);
  assign load      = active && !emit;
  assign cfg_clear = cfg_we && (cfg_index == dbwp_pkg::CFG_OUT_FORMAT ||
                                cfg_index == dbwp_pkg::CFG_TRACK_BYTES);

  always_comb begin
    ctl.load      = load;
    ctl.emit      = emit;
    ctl.clear     = emit || cfg_clear;
    ctl.slot      = slot_eff;
    ctl.len_m1    = len_m1;
    ctl.fmt       = out_format;
    ctl.bit_rev   = bit_rev;
    ctl.mono      = mono;
    ctl.last      = last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_format <= dbwp_pkg::FMT_U8;
      mono       <= 1'b0;
      bit_rev    <= 1'b0;
      remaining  <= '0;
      finished   <= 1'b0;
      byte_slot  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        dbwp_pkg::CFG_OUT_FORMAT: begin
          out_format <= cfg_data[dbwp_pkg::FMT_W-1:0];
          byte_slot  <= '0;
        end
        dbwp_pkg::CFG_MONO:    mono    <= cfg_data[0];
        dbwp_pkg::CFG_BIT_REV: bit_rev <= cfg_data[0];
        dbwp_pkg::CFG_TRACK_BYTES: begin
          remaining <= cfg_data[dbwp_pkg::COUNT_W-1:0];
          finished  <= 1'b0;
          byte_slot <= '0;
        end
        default: ;
      endcase
    end else if (active) begin
      remaining <= remaining - dbwp_pkg::COUNT_W'(1);
      if (emit) begin
        byte_slot <= '0;
        if (last) begin
          finished <= 1'b1;
        end
      end else begin
        byte_slot <= slot_eff + dbwp_pkg::SLOT_W'(1);
      end
    end
  end

  a_no_work_when_finished: assert property (@(posedge clk) disable iff (rst)
    finished |-> !(emit || load))
    else $error("byte taken after end of track");

  a_last_sets_finished: assert property (@(posedge clk) disable iff (rst)
    (emit && last && !cfg_we) |=> finished)
    else $error("last frame did not close the track");

endmodule

/* hdl/dbwp_merge.sv */
module dbwp_merge (
  input  logic                              clk,
  input  logic                              rst,
  input  dbwp_pkg::lane_ctl_t               ctl,
  input  logic [dbwp_pkg::WORD_W-1:0]       left_word,
  input  logic [dbwp_pkg::WORD_W-1:0]       right_word,
  output logic                              s_tready,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [2*dbwp_pkg::WORD_W-1:0]     m_tdata,
  output logic                              m_tlast
);

  logic [2*dbwp_pkg::WORD_W-1:0] res_data;
  logic                          out_valid;
  logic [2*dbwp_pkg::WORD_W-1:0] out_data;
  logic                          out_last;
  logic                          skid_valid;
  logic [2*dbwp_pkg::WORD_W-1:0] skid_data;
  logic                          skid_last;

  assign res_data = {(ctl.mono ? left_word : right_word), left_word};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (m_tready || !out_valid) begin
      // advance: skid first, else the fresh result
      if (skid_valid) begin
        out_valid  <= 1'b1;
        out_data   <= skid_data;
        out_last   <= skid_last;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= ctl.emit;
        out_data  <= res_data;
        out_last  <= ctl.last;
      end
    end else if (ctl.emit) begin
      // hold the result aside while the output stalls
      skid_valid <= 1'b1;
      skid_data  <= res_data;
      skid_last  <= ctl.last;
    end
  end

  assign s_tready = !skid_valid;
  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;
  assign m_tlast  = out_last;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid holds a beat with empty output stage");

endmodule

/* hdl/dsd_byte_to_word_packer.sv */
// Each frame's result is registered in the output stage, or in the skid stage if stalled.
// One byte pair per cycle while s_tready is high; a frame of 1, 2 or 4 beats gives one result.
// Output register plus skid stage keep s_tready high through one stalled result.
// Reset (rst, synchronous): control, gather and valid registers zero, U8 format, empty track;
// every beat is dropped until track_bytes is written.
module dsd_byte_to_word_packer (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [dbwp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dbwp_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [2*dbwp_pkg::BYTE_W-1:0]       s_tdata,   // right_byte, left_byte
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [2*dbwp_pkg::WORD_W-1:0]       m_tdata,   // right_word (left_word when mono), left_word
  output logic                                m_tlast    // track_end
);

  dbwp_pkg::lane_ctl_t           ctl;
  logic                          in_fire;
  logic [dbwp_pkg::WORD_W-1:0]   left_word;
  logic [dbwp_pkg::WORD_W-1:0]   right_word;

  assign in_fire = s_tvalid && s_tready;

  dbwp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_fire   (in_fire),
    .ctl       (ctl)
  );

  dbwp_lane u_lane_left (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .byte_in (s_tdata[dbwp_pkg::BYTE_W-1:0]),
    .word    (left_word)
  );

  dbwp_lane u_lane_right (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .byte_in (s_tdata[2*dbwp_pkg::BYTE_W-1:dbwp_pkg::BYTE_W]),
    .word    (right_word)
  );

  dbwp_merge u_merge (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .left_word  (left_word),
    .right_word (right_word),
    .s_tready   (s_tready),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast)
  );

endmodule
